>>> rtl/cbpq_pkg.sv
// ----------------------------------------------------------------------------
// cbpq_pkg
// Shared types and constants of the circular bucket priority queue.
// ----------------------------------------------------------------------------
package cbpq_pkg;

  localparam int unsigned NumBins     = 256;
  localparam int unsigned BinCapacity = 128;
  localparam int unsigned HandleBits  = 16;
  localparam int unsigned KeyShift    = 5;

  localparam int unsigned BinW   = $clog2(NumBins);
  localparam int unsigned SlotW  = (BinCapacity > 1) ? $clog2(BinCapacity) : 1;
  localparam int unsigned CountW = $clog2(BinCapacity + 1);
  localparam int unsigned AddrW  = BinW + SlotW;
  localparam int unsigned JW     = $clog2(NumBins + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] item_handle;
    logic [31:0] item_key;
  } req_t;

  typedef struct packed {
    logic [15:0] popped_handle;
    logic        popped_valid;
    logic        insert_overflow;
  } rsp_t;

endpackage

>>> rtl/cbpq_if.sv
// ----------------------------------------------------------------------------
// cbpq_req_if / cbpq_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface cbpq_req_if import cbpq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbpq_rsp_if import cbpq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/circular_bucket_priority_queue.sv
// ----------------------------------------------------------------------------
// circular_bucket_priority_queue
// Dial-style bucket queue with insert, remove and pop of the lowest bucket.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A remove reads every slot of its bin.
// A pop visits bins from the head, examines the slots of each bin it visits,
// and passes each empty bin on; a pop of an empty queue passes all bins. The
// walk is set by the single read port of the slot memory and the bin count
// memory. No clearing pass is needed after reset. The result register lets
// the next transaction be taken while a result waits.
module circular_bucket_priority_queue import cbpq_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  cbpq_req_if.sink    req,
  cbpq_rsp_if.source  rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_CNT_RD, S_CNT_WAIT, S_DISPATCH, S_REM_RD, S_REM_CHK,
    S_POP_RD, S_POP_CHK, S_POP_NEXT, S_DONE
  } state_e;

  // Memories: bin counts with valid bits, slot store (live bit + handle).
  logic [CountW-1:0]       cnt_mem [NumBins];
  logic [NumBins-1:0]      cnt_vld_q;
  logic [HandleBits:0]     slot_mem [NumBins*BinCapacity];

  state_e              state_q;
  logic [1:0]          op_q;
  logic [HandleBits-1:0] h_q;
  logic [31:0]         bucket_q, base_q;
  logic [BinW-1:0]     head_q, bin_q;
  logic [CountW-1:0]   cnt_q, idx_q, cnt_rd_q;
  logic                skip_q;
  logic [JW-1:0]       j_q;
  logic [HandleBits:0] slot_rd_q;
  logic                rsp_valid_q;
  rsp_t                rsp_q;
  rsp_t                res_q;

  logic [31:0]      diff;
  logic [BinW-1:0]  rel;
  logic [CountW-1:0] cnt_cur;
  logic [AddrW-1:0] addr;

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;

  // Clamp the relative bucket; the shared compare unit.
  assign diff = bucket_q - base_q;
  always_comb begin
    if (bucket_q < base_q) rel = '0;
    else if (diff >= 32'(NumBins)) rel = BinW'(NumBins - 1);
    else rel = diff[BinW-1:0];
  end
  assign cnt_cur = cnt_vld_q[bin_q] ? cnt_rd_q : '0;
  assign addr    = {bin_q, idx_q[SlotW-1:0]};

  // Registered reads of both memories.
  always_ff @(posedge clk_i) begin
    cnt_rd_q  <= cnt_mem[bin_q];
    slot_rd_q <= slot_mem[addr];
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; head_q <= '0; base_q <= '0; cnt_vld_q <= '0;
      rsp_valid_q <= 1'b0; op_q <= '0; bin_q <= '0;
    end else begin
      // The result register is loaded when it is free or being emptied.
      if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) rsp_valid_q <= 1'b1;
      else if (rsp.valid && rsp.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (req.valid && req.ready) begin
          op_q     <= req.data.opcode;
          h_q      <= req.data.item_handle[HandleBits-1:0];
          bucket_q <= {{KeyShift{1'b0}}, req.data.item_key[31:KeyShift]};
          res_q    <= '0;
          j_q      <= '0;
          state_q  <= S_CNT_RD;
        end
        S_CNT_RD: begin
          if (op_q == OP_POP) bin_q <= head_q;
          else bin_q <= BinW'((NumBins + 0) == 0 ? 0 : (rel + head_q) % NumBins);
          skip_q  <= (op_q == OP_REMOVE) && (bucket_q < base_q);
          state_q <= S_CNT_WAIT;
        end
        S_CNT_WAIT: state_q <= S_DISPATCH;
        S_DISPATCH: begin
          cnt_q <= cnt_cur;
          case (op_q)
            OP_INSERT: begin
              if (cnt_cur >= CountW'(BinCapacity)) res_q.insert_overflow <= 1'b1;
              else begin
                slot_mem[{bin_q, cnt_cur[SlotW-1:0]}] <= {1'b1, h_q};
                cnt_mem[bin_q]   <= cnt_cur + 1'b1;
                cnt_vld_q[bin_q] <= 1'b1;
              end
              state_q <= S_DONE;
            end
            OP_REMOVE: begin
              idx_q   <= '0;
              state_q <= (skip_q || cnt_cur == '0) ? S_DONE : S_REM_RD;
            end
            OP_POP: begin
              if (cnt_cur == '0) state_q <= S_POP_NEXT;
              else begin
                idx_q   <= cnt_cur - 1'b1;
                state_q <= S_POP_RD;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_REM_RD: state_q <= S_REM_CHK;
        S_REM_CHK: begin
          if (slot_rd_q[HandleBits] && slot_rd_q[HandleBits-1:0] == h_q)
            slot_mem[addr] <= {1'b0, slot_rd_q[HandleBits-1:0]};
          if (idx_q + 1'b1 >= cnt_q) state_q <= S_DONE;
          else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_REM_RD;
          end
        end
        S_POP_RD: state_q <= S_POP_CHK;
        S_POP_CHK: begin
          if (slot_rd_q[HandleBits]) begin
            cnt_mem[bin_q]   <= idx_q;
            cnt_vld_q[bin_q] <= 1'b1;
            res_q.popped_handle <= 16'(slot_rd_q[HandleBits-1:0]);
            res_q.popped_valid  <= 1'b1;
            state_q <= S_DONE;
          end else if (idx_q == '0) state_q <= S_POP_NEXT;
          else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= S_POP_RD;
          end
        end
        S_POP_NEXT: begin
          // Empty bin: clear its count and move head and base on.
          cnt_vld_q[bin_q] <= 1'b0;
          head_q  <= BinW'((bin_q + 1'b1) % NumBins);
          base_q  <= base_q + 1'b1;
          j_q     <= j_q + 1'b1;
          state_q <= (j_q + 1'b1 >= JW'(NumBins)) ? S_DONE : S_CNT_RD;
        end
        S_DONE: if (!rsp_valid_q || rsp.ready) begin
          rsp_q   <= res_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/cbpq_checker.sv
// ----------------------------------------------------------------------------
// cbpq_checker
// Port-level checks of the queue's result channel.
// ----------------------------------------------------------------------------
module cbpq_checker import cbpq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input rsp_t rsp_data_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i
);

  // A result never claims both a pop and an overflow.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_data_i.popped_valid && rsp_data_i.insert_overflow))
    else $error("pop and overflow together");

  // A handle is shown only with a valid pop.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_data_i.popped_valid |-> rsp_data_i.popped_handle == '0)
    else $error("handle without pop");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("result dropped");

  // No new transaction is taken in the cycle after one was accepted.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("back to back accept");

endmodule

bind circular_bucket_priority_queue cbpq_checker u_cbpq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req.valid), .req_ready_i(req.ready),
  .rsp_data_i(rsp.data), .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready)
);
